// File: rtl/core/rgb_to_hsv_convert_defines.svh
// Assertion macros for the checker file of the RGB to HSV converter.
`ifndef RGB_TO_HSV_CONVERT_DEFINES_SVH
`define RGB_TO_HSV_CONVERT_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define RHC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rgb_to_hsv_convert: same-cycle check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define RHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rgb_to_hsv_convert: next-cycle check failed");

`endif

// File: rtl/core/rhc_pkg.sv
`default_nettype none

package rhc_pkg;

    // Channel and result widths.
    localparam int CH_W   = 8;
    localparam int HUE_W  = 16;

    // Hue division: 10922 * |diff| fits in 22 bits, the quotient in 14.
    localparam int HNUM_W = 22;
    localparam int HQ_W   = 14;

    // Saturation division: span * 255 fits in 16 bits, the quotient in 8.
    localparam int SNUM_W = 16;
    localparam int SQ_W   = 8;

    // Quotient bits resolved per divider stage.
    localparam int BPS     = 2;
    localparam int DIV_STG = HQ_W / BPS;
    localparam int SAT_STG = SQ_W / BPS;

    // Pipeline depth: two front stages, the divider, one output stage.
    localparam int FRONT_STG = 2;
    localparam int NSTG      = FRONT_STG + DIV_STG + 1;

    // Hue circle constants.
    localparam logic [HQ_W-1:0]  HUE_SEXTANT    = 14'd10922;
    localparam logic [HUE_W-1:0] HUE_GREEN_BASE = 16'd21845;
    localparam logic [HUE_W-1:0] HUE_BLUE_BASE  = 16'd43690;
    localparam logic [HUE_W-1:0] HUE_WRAP       = 16'd65535;
    localparam logic [CH_W-1:0]  CHAN_FULL      = 8'd255;

    // Which channel holds the maximum.
    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // Side information that travels with a pixel through the divider.
    typedef struct packed {
        logic [CH_W-1:0] value;
        t_sector         sector;
        logic            neg;
        logic            grey;
    } t_side;

endpackage

`default_nettype wire

// File: rtl/core/rhc_front.sv
`default_nettype none

module rhc_front (
    input  wire logic                        i_clk,
    input  wire logic [1:0]                  i_en,
    input  wire logic [rhc_pkg::CH_W-1:0]    i_red,
    input  wire logic [rhc_pkg::CH_W-1:0]    i_green,
    input  wire logic [rhc_pkg::CH_W-1:0]    i_blue,
    output logic      [rhc_pkg::HNUM_W-1:0]  o_hnum,
    output logic      [rhc_pkg::CH_W-1:0]    o_hden,
    output logic      [rhc_pkg::SNUM_W-1:0]  o_snum,
    output logic      [rhc_pkg::CH_W-1:0]    o_sden,
    output rhc_pkg::t_side                   o_side
);
    import rhc_pkg::*;

    logic [CH_W-1:0] n_hi;
    logic [CH_W-1:0] n_lo;
    t_sector         n_sector;
    logic [CH_W:0]   n_diff;

    logic [CH_W-1:0] r1_value;
    logic [CH_W-1:0] r1_span;
    t_sector         r1_sector;
    logic            r1_neg;
    logic [CH_W-1:0] r1_mag;

    // Maximum with red, then green, winning ties; minimum; signed difference.
    always_comb begin
        n_hi = i_red;
        n_lo = i_red;
        if (i_green > n_hi) n_hi = i_green;
        if (i_blue > n_hi) n_hi = i_blue;
        if (i_green < n_lo) n_lo = i_green;
        if (i_blue < n_lo) n_lo = i_blue;
        if (n_hi == i_red) begin
            n_sector = SEC_RED;
            n_diff   = {1'b0, i_green} - {1'b0, i_blue};
        end else if (n_hi == i_green) begin
            n_sector = SEC_GREEN;
            n_diff   = {1'b0, i_blue} - {1'b0, i_red};
        end else begin
            n_sector = SEC_BLUE;
            n_diff   = {1'b0, i_red} - {1'b0, i_green};
        end
    end

    // Stage one keeps value, span, sector and the difference as sign and magnitude.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_value  <= n_hi;
            r1_span   <= n_hi - n_lo;
            r1_sector <= n_sector;
            r1_neg    <= n_diff[CH_W];
            r1_mag    <= n_diff[CH_W] ? CH_W'(-n_diff) : n_diff[CH_W-1:0];
        end
    end

    // Stage two forms both dividends.
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            o_hnum        <= HNUM_W'(r1_mag) * HNUM_W'(HUE_SEXTANT);
            o_hden        <= r1_span;
            o_snum        <= SNUM_W'(r1_span) * SNUM_W'(CHAN_FULL);
            o_sden        <= r1_value;
            o_side.value  <= r1_value;
            o_side.sector <= r1_sector;
            o_side.neg    <= r1_neg;
            o_side.grey   <= (r1_span == '0);
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/rhc_div.sv
`default_nettype none

module rhc_div (
    input  wire logic                         i_clk,
    input  wire logic [rhc_pkg::DIV_STG-1:0]  i_en,
    input  wire logic [rhc_pkg::HNUM_W-1:0]   i_hnum,
    input  wire logic [rhc_pkg::CH_W-1:0]     i_hden,
    input  wire logic [rhc_pkg::SNUM_W-1:0]   i_snum,
    input  wire logic [rhc_pkg::CH_W-1:0]     i_sden,
    input  rhc_pkg::t_side                    i_side,
    output logic      [rhc_pkg::HQ_W-1:0]     o_hq,
    output logic      [rhc_pkg::SQ_W-1:0]     o_sq,
    output rhc_pkg::t_side                    o_side
);
    import rhc_pkg::*;

    // Remainders and divisors are kept only where a later stage reads them.
    logic [HNUM_W-1:0] r_hrem [DIV_STG-1];
    logic [CH_W-1:0]   r_hden [DIV_STG-1];
    logic [HQ_W-1:0]   r_hq   [DIV_STG];
    logic [SNUM_W-1:0] r_srem [SAT_STG-1];
    logic [CH_W-1:0]   r_sden [SAT_STG-1];
    logic [SQ_W-1:0]   r_sq   [DIV_STG];
    t_side             r_side [DIV_STG];

    for (genvar j = 0; j < DIV_STG; j++) begin : g_stg
        localparam int K0 = HQ_W - 1 - BPS * j;

        logic [HNUM_W-1:0] in_hrem;
        logic [CH_W-1:0]   in_hden;
        logic [HQ_W-1:0]   in_hq;
        logic [SQ_W-1:0]   in_sq;
        t_side             in_side;
        logic [HNUM_W-1:0] h_trial;
        logic [HNUM_W-1:0] n_hrem;
        logic [HQ_W-1:0]   n_hq;
        logic [SQ_W-1:0]   n_sq;

        // Stage inputs come from the ports or from the previous stage.
        if (j == 0) begin : g_head
            assign in_hrem = i_hnum;
            assign in_hden = i_hden;
            assign in_hq   = '0;
            assign in_sq   = '0;
            assign in_side = i_side;
        end else begin : g_link
            assign in_hrem = r_hrem[j-1];
            assign in_hden = r_hden[j-1];
            assign in_hq   = r_hq[j-1];
            assign in_sq   = r_sq[j-1];
            assign in_side = r_side[j-1];
        end

        // Restoring division of the hue numerator, two quotient bits here.
        always_comb begin
            n_hrem  = in_hrem;
            n_hq    = in_hq;
            h_trial = '0;
            for (int b = 0; b < BPS; b++) begin
                h_trial = HNUM_W'(in_hden) << (K0 - b);
                n_hq    = {n_hq[HQ_W-2:0], 1'b0};
                if (n_hrem >= h_trial) begin
                    n_hrem  = n_hrem - h_trial;
                    n_hq[0] = 1'b1;
                end
            end
        end

        // Saturation runs in the first stages and then rides along.
        if (j < SAT_STG) begin : g_sdiv
            localparam int KS0 = SQ_W - 1 - BPS * j;

            logic [SNUM_W-1:0] in_srem;
            logic [CH_W-1:0]   in_sden;
            logic [SNUM_W-1:0] s_trial;
            logic [SNUM_W-1:0] n_srem;

            if (j == 0) begin : g_shead
                assign in_srem = i_snum;
                assign in_sden = i_sden;
            end else begin : g_slink
                assign in_srem = r_srem[j-1];
                assign in_sden = r_sden[j-1];
            end

            always_comb begin
                n_srem  = in_srem;
                n_sq    = in_sq;
                s_trial = '0;
                for (int b = 0; b < BPS; b++) begin
                    s_trial = SNUM_W'(in_sden) << (KS0 - b);
                    n_sq    = {n_sq[SQ_W-2:0], 1'b0};
                    if (n_srem >= s_trial) begin
                        n_srem  = n_srem - s_trial;
                        n_sq[0] = 1'b1;
                    end
                end
            end

            if (j < SAT_STG - 1) begin : g_sreg
                always_ff @(posedge i_clk) begin
                    if (i_en[j]) begin
                        r_srem[j] <= n_srem;
                        r_sden[j] <= in_sden;
                    end
                end
            end
        end else begin : g_spass
            assign n_sq = in_sq;
        end

        if (j < DIV_STG - 1) begin : g_hreg
            always_ff @(posedge i_clk) begin
                if (i_en[j]) begin
                    r_hrem[j] <= n_hrem;
                    r_hden[j] <= in_hden;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_hq[j]   <= n_hq;
                r_sq[j]   <= n_sq;
                r_side[j] <= in_side;
            end
        end
    end

    assign o_hq   = r_hq[DIV_STG-1];
    assign o_sq   = r_sq[DIV_STG-1];
    assign o_side = r_side[DIV_STG-1];

endmodule

`default_nettype wire

// File: rtl/core/rhc_back.sv
`default_nettype none

module rhc_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic [rhc_pkg::HQ_W-1:0]   i_hq,
    input  wire logic [rhc_pkg::SQ_W-1:0]   i_sq,
    input  rhc_pkg::t_side                  i_side,
    output logic      [rhc_pkg::HUE_W-1:0]  o_hue,
    output logic      [rhc_pkg::CH_W-1:0]   o_sat,
    output logic      [rhc_pkg::CH_W-1:0]   o_value
);
    import rhc_pkg::*;

    logic [HUE_W-1:0] n_hue;
    logic [HUE_W-1:0] hq_ext;

    assign hq_ext = HUE_W'(i_hq);

    // Sextant offset plus or minus the quotient; a negative red hue wraps.
    always_comb begin
        n_hue = '0;
        if (!i_side.grey) begin
            unique case (i_side.sector)
                SEC_RED: begin
                    if (i_side.neg && (i_hq != '0)) begin
                        n_hue = HUE_WRAP - hq_ext;
                    end else begin
                        n_hue = hq_ext;
                    end
                end
                SEC_GREEN: begin
                    n_hue = i_side.neg ? HUE_GREEN_BASE - hq_ext : HUE_GREEN_BASE + hq_ext;
                end
                SEC_BLUE: begin
                    n_hue = i_side.neg ? HUE_BLUE_BASE - hq_ext : HUE_BLUE_BASE + hq_ext;
                end
                default: begin
                    n_hue = '0;
                end
            endcase
        end
    end

    // Output register; a grey or black pixel has zero saturation.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_hue   <= n_hue;
            o_sat   <= i_side.grey ? '0 : i_sq;
            o_value <= i_side.value;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/rgb_to_hsv_convert.sv
// Channel   Direction  Handshake          Payload
// pixel     in         i_valid / o_ready  i_red_in, i_green_in, i_blue_in
// hsv       out        o_valid / i_ready  o_hue_out, o_saturation_out, o_value_out
//
// Ten register stages: min/max, dividends, seven divider stages, output.
// A pixel passes every stage from transfer in to result valid; one pixel per cycle while the output is not stalled.
// The divider stages, two quotient bits each, set the depth.
// Reset clears only the stage valid bits; the data path needs no reset.
// A stalled output holds; any empty stage lets the stages before it keep moving.
`default_nettype none

module rgb_to_hsv_convert (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [rhc_pkg::CH_W-1:0]    i_red_in,
    input  wire logic [rhc_pkg::CH_W-1:0]    i_green_in,
    input  wire logic [rhc_pkg::CH_W-1:0]    i_blue_in,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic      [rhc_pkg::HUE_W-1:0]   o_hue_out,
    output logic      [rhc_pkg::CH_W-1:0]    o_saturation_out,
    output logic      [rhc_pkg::CH_W-1:0]    o_value_out
);
    import rhc_pkg::*;

    logic [NSTG-1:0]   r_vld;
    logic [NSTG-1:0]   stg_en;

    logic [HNUM_W-1:0] f_hnum;
    logic [CH_W-1:0]   f_hden;
    logic [SNUM_W-1:0] f_snum;
    logic [CH_W-1:0]   f_sden;
    t_side             f_side;
    logic [HQ_W-1:0]   d_hq;
    logic [SQ_W-1:0]   d_sq;
    t_side             d_side;

    // A stage may load when it is empty or when its content moves on.
    always_comb begin
        stg_en[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (stg_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_ready = stg_en[0];
    assign o_valid = r_vld[NSTG-1];

    rhc_front u_front (
        .i_clk   (i_clk),
        .i_en    (stg_en[FRONT_STG-1:0]),
        .i_red   (i_red_in),
        .i_green (i_green_in),
        .i_blue  (i_blue_in),
        .o_hnum  (f_hnum),
        .o_hden  (f_hden),
        .o_snum  (f_snum),
        .o_sden  (f_sden),
        .o_side  (f_side)
    );

    rhc_div u_div (
        .i_clk  (i_clk),
        .i_en   (stg_en[FRONT_STG+DIV_STG-1:FRONT_STG]),
        .i_hnum (f_hnum),
        .i_hden (f_hden),
        .i_snum (f_snum),
        .i_sden (f_sden),
        .i_side (f_side),
        .o_hq   (d_hq),
        .o_sq   (d_sq),
        .o_side (d_side)
    );

    rhc_back u_back (
        .i_clk   (i_clk),
        .i_en    (stg_en[NSTG-1]),
        .i_hq    (d_hq),
        .i_sq    (d_sq),
        .i_side  (d_side),
        .o_hue   (o_hue_out),
        .o_sat   (o_saturation_out),
        .o_value (o_value_out)
    );

endmodule

`default_nettype wire

// File: rtl/core/rhc_checker.sv
`default_nettype none
`include "rgb_to_hsv_convert_defines.svh"

module rhc_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_ready,
    input wire logic                        o_valid,
    input wire logic                        i_ready,
    input wire logic [rhc_pkg::HUE_W-1:0]   o_hue_out,
    input wire logic [rhc_pkg::CH_W-1:0]    o_saturation_out,
    input wire logic [rhc_pkg::CH_W-1:0]    o_value_out
);
    import rhc_pkg::*;

    // A result that is not taken stays offered.
    `RHC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)

    // With the output stage empty, nothing upstream can be stalled.
    `RHC_ASSERT_NOW(a_empty_ready, i_clk, i_rst_n, !o_valid, o_ready)

    // Zero saturation means a grey pixel, whose hue is zero.
    `RHC_ASSERT_NOW(a_grey_hue, i_clk, i_rst_n, o_valid && (o_saturation_out == '0), o_hue_out == '0)

    // A black pixel has zero saturation, and the wrapped hue never reaches the seam.
    `RHC_ASSERT_NOW(a_black_sat, i_clk, i_rst_n, o_valid && (o_value_out == '0), (o_saturation_out == '0) && (o_hue_out != HUE_WRAP))

endmodule

bind rgb_to_hsv_convert rhc_checker u_rhc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_hue_out        (o_hue_out),
    .o_saturation_out (o_saturation_out),
    .o_value_out      (o_value_out)
);

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rhc_pkg::*;

    // Pixel in and HSV result out, at the block's widths.
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  sat;
        logic [CH_W-1:0]  val;
    } t_hsv;

    localparam int STALL_LIMIT    = 5000;
    localparam int PHASE_PIXELS   = 500;
    localparam int DRAIN_CYCLES   = 2 * NSTG;

    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_valid          = 1'b0;
    logic                i_ready          = 1'b0;
    logic [CH_W-1:0]     i_red_in         = '0;
    logic [CH_W-1:0]     i_green_in       = '0;
    logic [CH_W-1:0]     i_blue_in        = '0;
    logic                o_ready;
    logic                o_valid;
    logic [HUE_W-1:0]    o_hue_out;
    logic [CH_W-1:0]     o_saturation_out;
    logic [CH_W-1:0]     o_value_out;

    t_pixel pending_pixels[$];
    t_hsv   expected_hsv[$];
    int     send_idle_pct   = 0;
    int     recv_idle_pct   = 0;
    int     pixels_sent     = 0;
    int     results_checked = 0;
    int     mismatch_count  = 0;
    int     stall_cycles    = 0;

    rgb_to_hsv_convert dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_red_in         (i_red_in),
        .i_green_in       (i_green_in),
        .i_blue_in        (i_blue_in),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_hue_out        (o_hue_out),
        .o_saturation_out (o_saturation_out),
        .o_value_out      (o_value_out)
    );

    always #10 i_clk = ~i_clk;

    // Integer HSV conversion: value is the top channel, hue offset by the winning sector.
    function automatic t_hsv convert_pixel(input t_pixel px);
        int      r = px.red;
        int      g = px.green;
        int      b = px.blue;
        int      hi;
        int      lo;
        int      span;
        int      sat = 0;
        int      hue = 0;
        int      sextant = HUE_SEXTANT;
        t_sector sector;
        t_hsv    res;
        hi = r;
        lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        span = hi - lo;
        if (hi != 0) sat = (span * 255) / hi;
        // Ties go to red first, then green.
        if (hi == r) sector = SEC_RED;
        else if (hi == g) sector = SEC_GREEN;
        else sector = SEC_BLUE;
        if (sat != 0 && span != 0) begin
            case (sector)
                SEC_RED:   hue = (sextant * (g - b)) / span;
                SEC_GREEN: hue = int'(HUE_GREEN_BASE) + (sextant * (b - r)) / span;
                default:   hue = int'(HUE_BLUE_BASE) + (sextant * (r - g)) / span;
            endcase
        end
        // A negative red-sector hue wraps by one less than the full circle.
        if (hue < 0) hue += int'(HUE_WRAP);
        res.hue = hue[HUE_W-1:0];
        res.sat = sat[CH_W-1:0];
        res.val = hi[CH_W-1:0];
        return res;
    endfunction

    // Mostly uniform pixels, with greys, ties, channel extremes and wrapped red hues mixed in.
    function automatic t_pixel random_pixel();
        t_pixel px;
        int     hi;
        int     lo;
        int     mid;
        px.red   = CH_W'($urandom);
        px.green = CH_W'($urandom);
        px.blue  = CH_W'($urandom);
        case ($urandom_range(9))
            0: begin
                px.green = px.red;
                px.blue  = px.red;
            end
            1: begin
                hi = $urandom_range(1, 255);
                lo = $urandom_range(0, hi);
                case ($urandom_range(2))
                    0: px = '{CH_W'(hi), CH_W'(hi), CH_W'(lo)};
                    1: px = '{CH_W'(hi), CH_W'(lo), CH_W'(hi)};
                    default: px = '{CH_W'(lo), CH_W'(hi), CH_W'(hi)};
                endcase
            end
            2: begin
                if ($urandom_range(1)) px.red = $urandom_range(1) ? 8'd255 : 8'd0;
                if ($urandom_range(1)) px.green = $urandom_range(1) ? 8'd255 : 8'd0;
                if ($urandom_range(1)) px.blue = $urandom_range(1) ? 8'd255 : 8'd0;
            end
            3: begin
                // Red on top with blue above green gives a wrapped hue.
                hi  = $urandom_range(1, 255);
                mid = $urandom_range(0, hi);
                lo  = $urandom_range(0, mid);
                px  = '{CH_W'(hi), CH_W'(lo), CH_W'(mid)};
            end
            default: ;
        endcase
        return px;
    endfunction

    task automatic queue_pixel(input int r, input int g, input int b);
        pending_pixels.push_back('{CH_W'(r), CH_W'(g), CH_W'(b)});
    endtask

    // Block until every pixel has transferred and every result has come back.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_pixels.size() != 0 || i_valid || expected_hsv.size() != 0);
    endtask

    // Pixel driver: a new pixel goes out only once the previous one has transferred.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_hsv.push_back(convert_pixel('{i_red_in, i_green_in, i_blue_in}));
                pixels_sent++;
            end
            if (!i_valid || o_ready) begin
                if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_pixel px;
                    px = pending_pixels.pop_front();
                    i_valid    <= 1'b1;
                    i_red_in   <= px.red;
                    i_green_in <= px.green;
                    i_blue_in  <= px.blue;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result side back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    // Result monitor: each transfer is matched against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_hsv.size() == 0) begin
                $error("unexpected result: hue %0d saturation %0d value %0d",
                       o_hue_out, o_saturation_out, o_value_out);
                mismatch_count++;
            end else begin
                t_hsv exp_res;
                exp_res = expected_hsv.pop_front();
                check_field("hue_out", exp_res.hue, o_hue_out);
                check_field("saturation_out", exp_res.sat, o_saturation_out);
                check_field("value_out", exp_res.val, o_value_out);
                results_checked++;
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pixels: black, white, primaries, ties, greys and wrapped hues.
        send_idle_pct <= 28;
        recv_idle_pct <= 51;
        queue_pixel(0, 0, 0);
        queue_pixel(255, 255, 255);
        queue_pixel(255, 0, 0);
        queue_pixel(0, 255, 0);
        queue_pixel(0, 0, 255);
        queue_pixel(255, 255, 0);
        queue_pixel(0, 255, 255);
        queue_pixel(255, 0, 255);
        queue_pixel(128, 128, 128);
        queue_pixel(1, 1, 1);
        queue_pixel(255, 0, 1);
        queue_pixel(255, 254, 0);
        queue_pixel(1, 0, 0);
        queue_pixel(0, 1, 0);
        queue_pixel(0, 0, 1);
        queue_pixel(200, 100, 150);
        queue_pixel(100, 200, 50);
        queue_pixel(50, 100, 200);
        queue_pixel(255, 128, 127);
        queue_pixel(170, 85, 0);
        queue_pixel(1, 0, 1);
        queue_pixel(254, 255, 255);

        // Hold the sender back until the pipeline has emptied.
        wait_drained();

        // Three pacing phases: receiver-heavy idling, sender-heavy idling, none.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct <= (phase == 0) ? 28 : (phase == 1) ? 51 : 0;
            recv_idle_pct <= (phase == 0) ? 51 : (phase == 1) ? 28 : 0;
            for (int n = 0; n < PHASE_PIXELS; n++) pending_pixels.push_back(random_pixel());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d pixels and checked %0d HSV results", pixels_sent, results_checked);
        $display("across directed corners and three back-pressure phases.");
        if (mismatch_count == 0 && expected_hsv.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
